// ----- rtl/fssa_pkg.sv -----
// Package with shared constants and types for the splat accumulator.
package fssa_pkg;

  localparam int unsigned FilmWidth  = 64;
  localparam int unsigned FilmHeight = 64;
  localparam int unsigned TableSide  = 16;
  localparam int unsigned MaxRadius  = 4;

  localparam int unsigned SumW    = 40;
  localparam int unsigned WsumW   = 32;
  localparam int unsigned PixW    = 2 * SumW + WsumW + SumW;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_ADD  = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NOP  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    REG_RADIUS_X     = 3'd0,
    REG_RADIUS_Y     = 3'd1,
    REG_INV_RADIUS_X = 3'd2,
    REG_INV_RADIUS_Y = 3'd3,
    REG_MAX_LUM      = 3'd4,
    REG_OUT_SCALE    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [10:0] radius_x;
    logic [10:0] radius_y;
    logic [15:0] inv_radius_x;
    logic [15:0] inv_radius_y;
    logic [15:0] max_luminance;
    logic [15:0] output_scale;
  } cfg_t;

endpackage

// ----- rtl/fssa_ram.sv -----
// Generic single-port synchronous RAM with a registered read port.
module fssa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ----- rtl/fssa_div.sv -----
// Restoring divider for unsigned operands, one quotient bit per cycle.
module fssa_div #(
  parameter int unsigned Width = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             done_o,
  output logic [Width-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(Width + 1);

  logic [Width-1:0] rem_q, rem_d, quot_q, quot_d, den_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [Width:0]   trial;

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[Width-1]};
    if (start_i) begin
      rem_d  = '0;
      quot_d = dividend_i;
      cnt_d  = CntW'(Width);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = Width'(trial - {1'b0, den_q});
        quot_d = {quot_q[Width-2:0], 1'b1};
      end else begin
        rem_d  = trial[Width-1:0];
        quot_d = {quot_q[Width-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- rtl/filtered_sample_splat_accumulator.sv -----
// Top level of the filtered sample splat accumulator.
//
// Channel   Direction  Signals                                Handshake
// config    in         cfg_we_i, cfg_idx_i, cfg_data_i       write when cfg_we_i
// command   in         start_i, func_i and payload fields     start_i && !busy_o
// result    out        result_valid_o, out_*_o                one-cycle strobe
//
// After reset a clearing pass zeroes every word of the pixel memory; busy_o is
// high throughout it.
// A load writes one table entry; a read runs up to three serial divisions.
// An add clamps each channel by serial division when the luminance exceeds
// max_luminance, then reads, multiplies and writes each footprint pixel.
// The receiver cannot stall; each result is shown for exactly one cycle.
module filtered_sample_splat_accumulator
  import fssa_pkg::*;
#(
  parameter int unsigned FILM_WIDTH  = FilmWidth,
  parameter int unsigned FILM_HEIGHT = FilmHeight,
  parameter int unsigned TABLE_SIDE  = TableSide,
  parameter int unsigned MAX_RADIUS  = MaxRadius
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  func_i,
  input  logic [13:0] film_x_i,
  input  logic [13:0] film_y_i,
  input  logic [15:0] red_in_i,
  input  logic [15:0] green_in_i,
  input  logic [15:0] blue_in_i,
  input  logic [15:0] sample_weight_i,
  input  logic [7:0]  table_index_i,
  input  logic signed [15:0] table_weight_i,
  input  logic [5:0]  pixel_x_i,
  input  logic [5:0]  pixel_y_i,
  output logic        result_valid_o,
  output logic [15:0] out_red_o,
  output logic [15:0] out_green_o,
  output logic [15:0] out_blue_o,
  output logic        weight_was_zero_o
);

  localparam int unsigned NPix  = FILM_WIDTH * FILM_HEIGHT;
  localparam int unsigned NTab  = TABLE_SIDE * TABLE_SIDE;
  localparam int unsigned PixAW = (NPix > 1) ? $clog2(NPix) : 1;
  localparam int unsigned TabAW = (NTab > 1) ? $clog2(NTab) : 1;
  localparam int unsigned TsW   = $clog2(TABLE_SIDE);
  localparam int unsigned CxW   = $clog2(FILM_WIDTH + 1) + 1;
  localparam int unsigned CyW   = $clog2(FILM_HEIGHT + 1) + 1;
  localparam int unsigned RLim  = MAX_RADIUS * 256;
  localparam int unsigned DivW  = 48;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD,
    ST_LUM, ST_LDIV, ST_LDIVW, ST_SPAN,
    ST_TRD, ST_TWAIT, ST_MUL, ST_WRITE,
    ST_RRD, ST_RWAIT, ST_RDIV, ST_RDIVW, ST_RSCALE, ST_RSAT, ST_RDONE
  } state_e;

  state_e state_q;
  cfg_t   cfg_q;

  // Command latch.
  logic [13:0] fx_q, fy_q;
  logic [15:0] c_q [3];
  logic [15:0] sw_q;
  logic [7:0]  ti_q;
  logic [15:0] tw_q;
  logic [5:0]  rpx_q, rpy_q;

  logic [17:0] lum_q;
  logic [1:0]  ch_q;
  logic signed [CxW-1:0] x0_q, x1_q, px_q;
  logic signed [CyW-1:0] y1_q, py_q;
  logic signed [15:0] fw_q;
  logic [31:0] cs_q [3];
  logic signed [SumW-1:0] acc_q [3];
  logic [WsumW-1:0] wacc_q;
  logic [PixAW-1:0] clr_q;

  // Read path.
  logic signed [SumW-1:0] rs_q [3];
  logic signed [WsumW-1:0] rw_q;
  logic signed [40:0] v_q;
  logic [15:0] res_q [3];
  logic        wz_q, rv_q;

  // Memories.
  logic [PixAW-1:0] pa;
  logic             pwe;
  logic [PixW-1:0]  pwd, prd;
  logic [TabAW-1:0] ta;
  logic             twe;
  logic [15:0]      trd;

  fssa_ram #(.Width(PixW), .Depth(NPix)) u_pix (
    .clk_i, .we_i(pwe), .addr_i(pa), .wdata_i(pwd), .rdata_o(prd));
  fssa_ram #(.Width(16), .Depth(NTab)) u_tab (
    .clk_i, .we_i(twe), .addr_i(ta), .wdata_i(tw_q), .rdata_o(trd));

  // Shared divider.
  logic            dstart, ddone;
  logic [DivW-1:0] dnum, dden, dq;
  fssa_div #(.Width(DivW)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .dividend_i(dnum), .divisor_i(dden),
    .done_o(ddone), .quot_o(dq));

  // Footprint geometry.
  logic [10:0] rx, ry;
  assign rx = (32'(cfg_q.radius_x) > RLim) ? 11'(RLim) : cfg_q.radius_x;
  assign ry = (32'(cfg_q.radius_y) > RLim) ? 11'(RLim) : cfg_q.radius_y;

  logic signed [15:0] dx, dy;
  assign dx = 16'(signed'({2'b0, fx_q})) - 16'sd128;
  assign dy = 16'(signed'({2'b0, fy_q})) - 16'sd128;

  function automatic logic signed [15:0] ceil_div256(input logic signed [15:0] v);
    ceil_div256 = (v + 16'sd255) >>> 8;
  endfunction

  logic signed [15:0] ax, bx, ay, by;
  assign ax = ceil_div256(dx - 16'(signed'({1'b0, rx})));
  assign bx = ((dx + 16'(signed'({1'b0, rx}))) >>> 8) + 16'sd1;
  assign ay = ceil_div256(dy - 16'(signed'({1'b0, ry})));
  assign by = ((dy + 16'(signed'({1'b0, ry}))) >>> 8) + 16'sd1;

  function automatic logic [TsW-1:0] tpos(input logic signed [15:0] p,
                                          input logic signed [15:0] d,
                                          input logic [15:0] inv);
    logic signed [25:0] diff;
    logic [25:0] ad;
    logic [49:0] f;
    diff = 26'(signed'(p)) * 26'sd256 - 26'(signed'(d));
    ad   = diff[25] ? 26'(-diff) : 26'(diff);
    f    = (50'(ad) * 50'(inv) * 50'(TABLE_SIDE)) >> 16;
    if (f > 50'(TABLE_SIDE - 1)) begin
      tpos = TsW'(TABLE_SIDE - 1);
    end else begin
      tpos = f[TsW-1:0];
    end
  endfunction

  logic [TsW-1:0] ix, iy;
  assign ix = tpos(16'(px_q), dx, cfg_q.inv_radius_x);
  assign iy = tpos(16'(py_q), dy, cfg_q.inv_radius_y);

  logic [PixAW-1:0] pix_add, pix_rd;
  assign pix_add = PixAW'(32'(py_q) * FILM_WIDTH + 32'(px_q));
  assign pix_rd  = PixAW'(32'(rpy_q) * FILM_WIDTH + 32'(rpx_q));

  // Pixel word unpacking.
  logic signed [SumW-1:0]  m_s [3];
  logic signed [WsumW-1:0] m_w;
  assign m_s[0] = prd[PixW-1 -: SumW];
  assign m_s[1] = prd[PixW-1-SumW -: SumW];
  assign m_s[2] = prd[PixW-1-2*SumW -: SumW];
  assign m_w    = prd[WsumW-1:0];

  always_comb begin
    pa   = clr_q;
    pwe  = 1'b0;
    pwd  = {acc_q[0], acc_q[1], acc_q[2], wacc_q};
    ta   = TabAW'(ti_q);
    twe  = 1'b0;
    dstart = 1'b0;
    dnum = 48'(c_q[ch_q]) * 48'(cfg_q.max_luminance);
    dden = 48'(lum_q);
    case (state_q)
      ST_CLEAR: begin
        pwe = 1'b1;
        pwd = '0;
      end
      ST_LOAD: twe = 1'b1;
      ST_LDIV: dstart = 1'b1;
      ST_TRD, ST_TWAIT, ST_MUL: begin
        pa = pix_add;
        ta = TabAW'(32'(iy) * TABLE_SIDE + 32'(ix));
      end
      ST_WRITE: begin
        pa  = pix_add;
        pwe = 1'b1;
      end
      ST_RRD, ST_RWAIT: pa = pix_rd;
      ST_RDIV: begin
        dstart = 1'b1;
        dnum = rs_q[ch_q][SumW-1] ? 48'(-(48'(rs_q[ch_q]) <<< 7))
                                  : 48'(48'(rs_q[ch_q]) << 7);
        dden = rw_q[WsumW-1] ? 48'(-48'(rw_q)) : 48'(rw_q);
      end
      default: ;
    endcase
  end

  // Quotient sign and output scaling; a negative quotient is clamped to zero.
  logic neg_q;
  logic signed [56:0] scaled;
  assign scaled = 57'(v_q) * 57'(signed'({1'b0, cfg_q.output_scale}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      rv_q    <= 1'b0;
      cfg_q   <= '{radius_x: 11'd512, radius_y: 11'd512, inv_radius_x: 16'd128,
                   inv_radius_y: 16'd128, max_luminance: 16'hFFFF,
                   output_scale: 16'd256};
      ch_q    <= '0;
    end else begin
      rv_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RADIUS_X:     cfg_q.radius_x      <= cfg_data_i[10:0];
          REG_RADIUS_Y:     cfg_q.radius_y      <= cfg_data_i[10:0];
          REG_INV_RADIUS_X: cfg_q.inv_radius_x  <= cfg_data_i;
          REG_INV_RADIUS_Y: cfg_q.inv_radius_y  <= cfg_data_i;
          REG_MAX_LUM:      cfg_q.max_luminance <= cfg_data_i;
          REG_OUT_SCALE:    cfg_q.output_scale  <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (32'(clr_q) == NPix - 1) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start_i) begin
            fx_q <= film_x_i; fy_q <= film_y_i;
            c_q[0] <= red_in_i; c_q[1] <= green_in_i; c_q[2] <= blue_in_i;
            sw_q <= sample_weight_i; ti_q <= table_index_i; tw_q <= table_weight_i;
            rpx_q <= pixel_x_i; rpy_q <= pixel_y_i;
            ch_q <= '0;
            case (func_e'(func_i))
              FUNC_LOAD: state_q <= (32'(table_index_i) < NTab) ? ST_LOAD : ST_IDLE;
              FUNC_ADD:  state_q <= ST_LUM;
              FUNC_READ: begin
                if (32'(pixel_x_i) >= FILM_WIDTH || 32'(pixel_y_i) >= FILM_HEIGHT) begin
                  res_q[0] <= '0; res_q[1] <= '0; res_q[2] <= '0;
                  wz_q <= 1'b1;
                  rv_q <= 1'b1;
                end else begin
                  state_q <= ST_RRD;
                end
              end
              default: ;
            endcase
          end
        end
        ST_LOAD: state_q <= ST_IDLE;
        ST_LUM: begin
          lum_q <= 18'((34'(c_q[0]) * 34'd13938 + 34'(c_q[1]) * 34'd46868
                       + 34'(c_q[2]) * 34'd4730) >> 16);
          state_q <= ST_LDIV;
        end
        ST_LDIV: begin
          if (lum_q > 18'(cfg_q.max_luminance)) state_q <= ST_LDIVW;
          else state_q <= ST_SPAN;
        end
        ST_LDIVW: begin
          if (ddone) begin
            c_q[ch_q] <= dq[15:0];
            if (ch_q == 2'd2) begin
              state_q <= ST_SPAN;
            end else begin
              ch_q <= ch_q + 1'b1;
              state_q <= ST_LDIV;
            end
          end
        end
        ST_SPAN: begin
          x0_q <= (ax < 0) ? '0 : CxW'(ax);
          x1_q <= (bx > 16'(FILM_WIDTH)) ? CxW'(FILM_WIDTH) : CxW'(bx);
          px_q <= (ax < 0) ? '0 : CxW'(ax);
          py_q <= (ay < 0) ? '0 : CyW'(ay);
          y1_q <= (by > 16'(FILM_HEIGHT)) ? CyW'(FILM_HEIGHT) : CyW'(by);
          state_q <= ST_TRD;
        end
        ST_TRD: begin
          if (py_q >= y1_q || x0_q >= x1_q) state_q <= ST_IDLE;
          else state_q <= ST_TWAIT;
        end
        ST_TWAIT: begin
          fw_q <= trd;
          cs_q[0] <= 32'(c_q[0]) * 32'(sw_q);
          cs_q[1] <= 32'(c_q[1]) * 32'(sw_q);
          cs_q[2] <= 32'(c_q[2]) * 32'(sw_q);
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          for (int k = 0; k < 3; k++) begin
            acc_q[k] <= m_s[k] + SumW'((49'(signed'({1'b0, cs_q[k]})) * 49'(fw_q)) >>> 21);
          end
          wacc_q <= m_w + WsumW'(fw_q);
          state_q <= ST_WRITE;
        end
        ST_WRITE: begin
          if (px_q + 1'b1 >= x1_q) begin
            px_q <= x0_q;
            py_q <= py_q + 1'b1;
          end else begin
            px_q <= px_q + 1'b1;
          end
          state_q <= ST_TRD;
        end
        ST_RRD: state_q <= ST_RWAIT;
        ST_RWAIT: begin
          rs_q[0] <= m_s[0]; rs_q[1] <= m_s[1]; rs_q[2] <= m_s[2];
          rw_q <= m_w;
          wz_q <= (m_w == '0);
          state_q <= ST_RDIV;
        end
        ST_RDIV: begin
          neg_q <= rs_q[ch_q][SumW-1] ^ rw_q[WsumW-1];
          if (rw_q == '0) begin
            v_q <= 41'(rs_q[ch_q] >>> 8);
            state_q <= ST_RSCALE;
          end else begin
            state_q <= ST_RDIVW;
          end
        end
        ST_RDIVW: begin
          if (ddone) begin
            if (neg_q) v_q <= '0;
            else if (dq > 48'hFFFF_FFFF) v_q <= 41'h0_FFFF_FFFF;
            else v_q <= 41'(dq);
            state_q <= ST_RSCALE;
          end
        end
        ST_RSCALE: begin
          v_q <= 41'(scaled >>> 8);
          state_q <= ST_RSAT;
        end
        ST_RSAT: begin
          if (v_q < 0) res_q[ch_q] <= '0;
          else if (v_q > 41'sd65535) res_q[ch_q] <= 16'hFFFF;
          else res_q[ch_q] <= v_q[15:0];
          if (ch_q == 2'd2) begin
            state_q <= ST_RDONE;
          end else begin
            ch_q <= ch_q + 1'b1;
            state_q <= ST_RDIV;
          end
        end
        ST_RDONE: begin
          rv_q <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o            = (state_q != ST_IDLE);
  assign result_valid_o    = rv_q;
  assign out_red_o         = res_q[0];
  assign out_green_o       = res_q[1];
  assign out_blue_o        = res_q[2];
  assign weight_was_zero_o = wz_q;

  a_no_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pwe)
    else $error("pixel write while idle");
  a_res_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |=> !rv_q)
    else $error("result strobe longer than one cycle");
  a_wr_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> $past(state_q == ST_MUL))
    else $error("pixel write without modify");

endmodule
